FILE: rtl/rau_pkg.sv
// Types and constants for the rational arithmetic unit.
// Depends on nothing; used by rtl/rational_arith_unit.sv.
package rau_pkg;

   // Operand width of every input numerator and denominator.
   localparam int OPERAND_WIDTH = 16;
   // Magnitude width inside the unit: a sum of two cross products.
   localparam int VAL_WIDTH     = 2 * OPERAND_WIDTH + 1;
   // Result field widths.
   localparam int NUM_OUT_WIDTH = 32;
   localparam int DEN_OUT_WIDTH = 31;
   // Width used for the output saturation compare.
   localparam int CMP_WIDTH     = (VAL_WIDTH > NUM_OUT_WIDTH) ? VAL_WIDTH : NUM_OUT_WIDTH;
   // Bit counter of the divider and trailing-zero count of the GCD.
   localparam int CNT_WIDTH     = $clog2(VAL_WIDTH);

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                          cmd;
      logic signed [OPERAND_WIDTH-1:0]  num_a;
      logic signed [OPERAND_WIDTH-1:0]  den_a;
      logic signed [OPERAND_WIDTH-1:0]  num_b;
      logic signed [OPERAND_WIDTH-1:0]  den_b;
   } req_payload_type;

   typedef struct packed {
      logic signed [NUM_OUT_WIDTH-1:0]  num_out;
      logic [DEN_OUT_WIDTH-1:0]         den_out;
      logic                             div_error;
   } rsp_payload_type;

endpackage

FILE: rtl/rational_arith_unit.sv
// Rational arithmetic unit: one shared multiplier, binary GCD and restoring divider.
// Depends on rtl/rau_pkg.sv for the payload types, the command codes and the widths.
//
// Each request beat carries a command (add, subtract, multiply, divide) and two signed
// fractions; each gives exactly one response beat holding the result in lowest terms with
// a positive denominator, or 0/1 with div_error set when a denominator is zero or a divide
// has a zero divisor. The unit works on one beat at a time and req_ready is high only while
// it is idle; a finished response waits in the output register, so the next request may be
// taken before the previous response is collected. With W = OPERAND_WIDTH and V = 2W+1, a
// beat forms the three cross products on the single multiplier, then runs binary GCD on
// the V-bit magnitudes (one subtract or shift per cycle), then the two exact divisions by
// the GCD on the one-bit-per-cycle divider, then forms the response. The error cases go
// straight from capture to the response step, and a zero numerator from the combine step.
module rational_arith_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  rau_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rau_pkg::rsp_payload_type rsp_payload
);

   localparam int OW = rau_pkg::OPERAND_WIDTH;
   localparam int VW = rau_pkg::VAL_WIDTH;
   localparam int CW = rau_pkg::CMP_WIDTH;
   localparam int NW = rau_pkg::CNT_WIDTH;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_COMBINE,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_FINISH
   } state_type;

   // Registers.
   state_type                state_ff, state_in;
   rau_pkg::cmd_type         cmd_ff, cmd_in;
   logic [OW-1:0]            na_mag_ff, na_mag_in, da_mag_ff, da_mag_in;
   logic [OW-1:0]            nb_mag_ff, nb_mag_in, db_mag_ff, db_mag_in;
   logic                     na_neg_ff, na_neg_in, da_neg_ff, da_neg_in;
   logic                     nb_neg_ff, nb_neg_in, db_neg_ff, db_neg_in;
   logic [1:0]               step_ff, step_in;
   logic [VW-1:0]            t1_mag_ff, t1_mag_in, t2_mag_ff, t2_mag_in;
   logic                     t1_neg_ff, t1_neg_in, t2_neg_ff, t2_neg_in;
   logic [VW-1:0]            dm_mag_ff, dm_mag_in;
   logic                     dm_neg_ff, dm_neg_in;
   logic [VW-1:0]            ga_ff, ga_in, gb_ff, gb_in, g_ff, g_in;
   logic [NW-1:0]            k_ff, k_in;
   logic [VW-1:0]            quo_ff, quo_in, rem_ff, rem_in, nq_ff, nq_in;
   logic [NW-1:0]            cnt_ff, cnt_in;
   logic                     zero_ff, zero_in, err_ff, err_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rau_pkg::rsp_payload_type rsp_ff, rsp_in;

   // Shared multiplier.
   logic [OW-1:0]            mul_x, mul_y;
   logic                     mul_xneg, mul_yneg;
   logic [2*OW-1:0]          mul_p;

   // Operand magnitudes of the incoming beat.
   logic [OW-1:0]            in_na_mag, in_da_mag, in_nb_mag, in_db_mag;

   // Signed-magnitude add, GCD and divider datapath.
   logic [VW-1:0]            sum_mag, diff_ab, diff_ba;
   logic                     diff_borrow;
   logic [VW-1:0]            n_mag_c;
   logic                     n_neg_c;
   logic [VW:0]              g_diff;
   logic [VW:0]              rem_sh;
   logic [VW+1:0]            trial;
   logic                     div_borrow;
   logic                     div_last;

   // Response formation.
   logic                     res_neg;
   logic [CW-1:0]            nmag_ext, dmag_ext, num_lim, nsat, dsat;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Magnitudes of the request operands (two's complement negate of negative values).
   assign in_na_mag = req_payload.num_a[OW-1] ? (~req_payload.num_a + 1'b1) : req_payload.num_a;
   assign in_da_mag = req_payload.den_a[OW-1] ? (~req_payload.den_a + 1'b1) : req_payload.den_a;
   assign in_nb_mag = req_payload.num_b[OW-1] ? (~req_payload.num_b + 1'b1) : req_payload.num_b;
   assign in_db_mag = req_payload.den_b[OW-1] ? (~req_payload.den_b + 1'b1) : req_payload.den_b;

   // Operand selection for the multiplier: first term, second term, denominator.
   always_comb begin
      case (step_ff)
         2'd0: begin
            mul_x    = na_mag_ff;
            mul_xneg = na_neg_ff;
            mul_y    = (cmd_ff == rau_pkg::CMD_MUL) ? nb_mag_ff : db_mag_ff;
            mul_yneg = (cmd_ff == rau_pkg::CMD_MUL) ? nb_neg_ff : db_neg_ff;
         end
         2'd1: begin
            mul_x    = nb_mag_ff;
            mul_xneg = nb_neg_ff ^ (cmd_ff == rau_pkg::CMD_SUB);
            mul_y    = da_mag_ff;
            mul_yneg = da_neg_ff;
         end
         default: begin
            mul_x    = da_mag_ff;
            mul_xneg = da_neg_ff;
            mul_y    = (cmd_ff == rau_pkg::CMD_DIV) ? nb_mag_ff : db_mag_ff;
            mul_yneg = (cmd_ff == rau_pkg::CMD_DIV) ? nb_neg_ff : db_neg_ff;
         end
      endcase
   end

   assign mul_p = mul_x * mul_y;

   // Signed-magnitude sum of the two cross products.
   assign sum_mag     = t1_mag_ff + t2_mag_ff;
   assign {diff_borrow, diff_ab} = {1'b0, t1_mag_ff} - {1'b0, t2_mag_ff};
   assign diff_ba     = t2_mag_ff - t1_mag_ff;

   always_comb begin
      if ((cmd_ff == rau_pkg::CMD_ADD) || (cmd_ff == rau_pkg::CMD_SUB)) begin
         if (t1_neg_ff == t2_neg_ff) begin
            n_mag_c = sum_mag;
            n_neg_c = t1_neg_ff;
         end else if (!diff_borrow) begin
            n_mag_c = diff_ab;
            n_neg_c = t1_neg_ff;
         end else begin
            n_mag_c = diff_ba;
            n_neg_c = t2_neg_ff;
         end
      end else begin
         n_mag_c = t1_mag_ff;
         n_neg_c = t1_neg_ff;
      end
   end

   // GCD subtractor and divider trial subtraction.
   assign g_diff     = {1'b0, ga_ff} - {1'b0, gb_ff};
   assign rem_sh     = {rem_ff, quo_ff[VW-1]};
   assign trial      = {1'b0, rem_sh} - {2'b00, g_ff};
   assign div_borrow = trial[VW+1];
   assign div_last   = (cnt_ff == NW'(VW - 1));

   // Saturation of the reduced magnitudes into the response fields.
   assign res_neg  = t1_neg_ff ^ dm_neg_ff;
   assign nmag_ext = CW'(nq_ff);
   assign dmag_ext = CW'(quo_ff);
   assign num_lim  = res_neg ? (CW'(1) << (rau_pkg::NUM_OUT_WIDTH - 1))
                             : ((CW'(1) << (rau_pkg::NUM_OUT_WIDTH - 1)) - CW'(1));
   assign nsat     = (nmag_ext > num_lim) ? num_lim : nmag_ext;
   assign dsat     = (dmag_ext > ((CW'(1) << rau_pkg::DEN_OUT_WIDTH) - CW'(1)))
                     ? ((CW'(1) << rau_pkg::DEN_OUT_WIDTH) - CW'(1)) : dmag_ext;

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      na_mag_in    = na_mag_ff;
      da_mag_in    = da_mag_ff;
      nb_mag_in    = nb_mag_ff;
      db_mag_in    = db_mag_ff;
      na_neg_in    = na_neg_ff;
      da_neg_in    = da_neg_ff;
      nb_neg_in    = nb_neg_ff;
      db_neg_in    = db_neg_ff;
      step_in      = step_ff;
      t1_mag_in    = t1_mag_ff;
      t1_neg_in    = t1_neg_ff;
      t2_mag_in    = t2_mag_ff;
      t2_neg_in    = t2_neg_ff;
      dm_mag_in    = dm_mag_ff;
      dm_neg_in    = dm_neg_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      g_in         = g_ff;
      k_in         = k_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      nq_in        = nq_ff;
      cnt_in       = cnt_ff;
      zero_in      = zero_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (state_ff)
         // Capture the operands as sign and magnitude; catch the error cases at once.
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_payload.cmd;
               na_mag_in = in_na_mag;
               da_mag_in = in_da_mag;
               nb_mag_in = in_nb_mag;
               db_mag_in = in_db_mag;
               na_neg_in = req_payload.num_a[OW-1];
               da_neg_in = req_payload.den_a[OW-1];
               nb_neg_in = req_payload.num_b[OW-1];
               db_neg_in = req_payload.den_b[OW-1];
               step_in   = 2'd0;
               zero_in   = 1'b0;
               err_in    = 1'b0;
               if ((in_da_mag == '0) || (in_db_mag == '0) ||
                   ((req_payload.cmd == rau_pkg::CMD_DIV) && (in_nb_mag == '0))) begin
                  err_in   = 1'b1;
                  zero_in  = 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end

         // Three products on the one multiplier.
         ST_MUL: begin
            case (step_ff)
               2'd0: begin
                  t1_mag_in = VW'(mul_p);
                  t1_neg_in = (mul_xneg ^ mul_yneg) && (mul_p != '0);
               end
               2'd1: begin
                  t2_mag_in = VW'(mul_p);
                  t2_neg_in = (mul_xneg ^ mul_yneg) && (mul_p != '0);
               end
               default: begin
                  dm_mag_in = VW'(mul_p);
                  dm_neg_in = mul_xneg ^ mul_yneg;
               end
            endcase
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd2) begin
               state_in = ST_COMBINE;
            end
         end

         // Form the result numerator; a zero numerator goes straight to 0/1.
         ST_COMBINE: begin
            t1_mag_in = n_mag_c;
            t1_neg_in = n_neg_c;
            ga_in     = n_mag_c;
            gb_in     = dm_mag_ff;
            k_in      = '0;
            if (n_mag_c == '0) begin
               zero_in  = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_GCD;
            end
         end

         // Binary GCD, one shift or subtract per cycle.
         ST_GCD: begin
            if (ga_ff == gb_ff) begin
               g_in     = ga_ff << k_ff;
               quo_in   = t1_mag_ff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = ST_DIVN;
            end else if (!ga_ff[0] && !gb_ff[0]) begin
               ga_in = ga_ff >> 1;
               gb_in = gb_ff >> 1;
               k_in  = k_ff + 1'b1;
            end else if (!ga_ff[0]) begin
               ga_in = ga_ff >> 1;
            end else if (!gb_ff[0]) begin
               gb_in = gb_ff >> 1;
            end else if (!g_diff[VW]) begin
               ga_in = g_diff[VW-1:0];
            end else begin
               gb_in = ~g_diff[VW-1:0] + 1'b1;
            end
         end

         // Restoring division of the numerator, then of the denominator, by the GCD.
         ST_DIVN, ST_DIVD: begin
            rem_in = div_borrow ? rem_sh[VW-1:0] : trial[VW-1:0];
            quo_in = {quo_ff[VW-2:0], !div_borrow};
            cnt_in = cnt_ff + 1'b1;
            if (div_last) begin
               cnt_in = '0;
               if (state_ff == ST_DIVN) begin
                  nq_in    = {quo_ff[VW-2:0], !div_borrow};
                  quo_in   = dm_mag_ff;
                  rem_in   = '0;
                  state_in = ST_DIVD;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         // Load the response register once it is free.
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (zero_ff) begin
                  rsp_in.num_out = '0;
                  rsp_in.den_out = rau_pkg::DEN_OUT_WIDTH'(1);
               end else begin
                  rsp_in.num_out = res_neg ? (~nsat[rau_pkg::NUM_OUT_WIDTH-1:0] + 1'b1)
                                           : nsat[rau_pkg::NUM_OUT_WIDTH-1:0];
                  rsp_in.den_out = dsat[rau_pkg::DEN_OUT_WIDTH-1:0];
               end
               rsp_in.div_error = err_ff;
               rsp_valid_in     = 1'b1;
               state_in         = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State, datapath and response registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff    <= cmd_in;
      na_mag_ff <= na_mag_in;
      da_mag_ff <= da_mag_in;
      nb_mag_ff <= nb_mag_in;
      db_mag_ff <= db_mag_in;
      na_neg_ff <= na_neg_in;
      da_neg_ff <= da_neg_in;
      nb_neg_ff <= nb_neg_in;
      db_neg_ff <= db_neg_in;
      step_ff   <= step_in;
      t1_mag_ff <= t1_mag_in;
      t1_neg_ff <= t1_neg_in;
      t2_mag_ff <= t2_mag_in;
      t2_neg_ff <= t2_neg_in;
      dm_mag_ff <= dm_mag_in;
      dm_neg_ff <= dm_neg_in;
      ga_ff     <= ga_in;
      gb_ff     <= gb_in;
      g_ff      <= g_in;
      k_ff      <= k_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      nq_ff     <= nq_in;
      cnt_ff    <= cnt_in;
      zero_ff   <= zero_in;
      err_ff    <= err_in;
      rsp_ff    <= rsp_in;
   end

   // The GCD operands never reach zero, or the search would not end.
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_GCD) |-> ((ga_ff != '0) && (gb_ff != '0)))
      else $error("GCD operand reached zero");

   // Division by the GCD is exact: no remainder after the last bit.
   a_div_exact: assert property (@(posedge clock) disable iff (reset)
      (((state_ff == ST_DIVN) || (state_ff == ST_DIVD)) && div_last) |-> (rem_in == '0))
      else $error("division by the GCD left a remainder");

   // An error beat is always 0/1.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.div_error) |->
      ((rsp_payload.num_out == '0) && (rsp_payload.den_out == rau_pkg::DEN_OUT_WIDTH'(1))))
      else $error("error beat is not 0/1");

   // Every response denominator is at least one.
   a_den_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.den_out != '0))
      else $error("zero denominator in a response beat");

endmodule
